FILE: hdl/sact_pkg.sv
`timescale 1ns / 1ps

package sact_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int COUNT_BITS = 16;

	localparam int FUNC_W   = 2;
	localparam int POS_W    = 6;
	localparam int DIM_W    = 7;
	localparam int AREA_W   = 28;
	localparam int STATUS_W = 2;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int ADDR_W = COL_W + ROW_W;
	localparam int CELLS  = 1 << ADDR_W;

	// area cells keep headroom for tables left inconsistent by a resize
	localparam int SUM_W  = 32;
	localparam int ACC_W  = SUM_W + 2;
	localparam int PART_W = 2 * DIM_W;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = DIM_W;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [AREA_W-1:0]     AREA_MAX  = '1;

	typedef enum logic [FUNC_W-1:0] {
		FN_INSERT = 2'd0,
		FN_REMOVE = 2'd1,
		FN_QUERY  = 2'd2
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_UNCOVERED = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ALU_HOLD,
		ALU_LOAD,
		ALU_ACC_ADD,
		ALU_ACC_SUB,
		ALU_CELL_ADD,
		ALU_CELL_SUB
	} alu_op_t;

	typedef struct packed {
		logic [COL_W-1:0] x0;
		logic [ROW_W-1:0] y0;
		logic [DIM_W-1:0] x_end;
		logic [DIM_W-1:0] y_end;
	} scan_cfg_t;

	typedef struct packed {
		logic             valid;
		logic             last;
		logic [COL_W-1:0] x;
		logic [ROW_W-1:0] y;
	} scan_pt_t;

endpackage

FILE: hdl/sact_req_if.sv
`timescale 1ns / 1ps

interface sact_req_if import sact_pkg::*;;
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [POS_W-1:0]    rect_x;
	logic [POS_W-1:0]    rect_y;
	logic [DIM_W-1:0]    rect_w;
	logic [DIM_W-1:0]    rect_h;

	modport source(output valid, func, rect_x, rect_y, rect_w, rect_h, input ready);
	modport sink(input valid, func, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

FILE: hdl/sact_rsp_if.sv
`timescale 1ns / 1ps

interface sact_rsp_if import sact_pkg::*;;
	logic                valid;
	logic                ready;
	logic [AREA_W-1:0]   covered_area;
	logic [STATUS_W-1:0] status;

	modport source(output valid, covered_area, status, input ready);
	modport sink(input valid, covered_area, status, output ready);
endinterface

FILE: hdl/summed_area_coverage_table_top.sv
// a query reads its four corner cells; rejected and empty items go straight to the result step
// insert and remove walk the count and area memories one cell a cycle through their single
//   read and write ports: a check sweep over the rectangle, then an update sweep to the grid corner
// one request at a time; the next request is taken while a result still waits on rsp
// reset: after arst_n releases, a clearing pass over every cell zeroes both memories with req.ready low
`timescale 1ns / 1ps

module summed_area_coverage_table_top import sact_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	sact_req_if.sink              req,
	sact_rsp_if.source            rsp
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_UPDATE,
		S_QUERY,
		S_QWAIT,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   clr_q;
	logic [DIM_W-1:0]    width_q;
	logic [DIM_W-1:0]    height_q;
	logic [COL_W-1:0]    rx_q;
	logic [ROW_W-1:0]    ry_q;
	logic [DIM_W-1:0]    rw_q;
	logic [DIM_W-1:0]    rh_q;
	logic [DIM_W-1:0]    gw_q;
	logic [DIM_W-1:0]    gh_q;
	logic [FUNC_W-1:0]   func_q;
	logic [1:0]          qidx_q;
	logic                query_q;
	status_t             res_status_q;
	logic                rsp_valid_q;
	logic [AREA_W-1:0]   rsp_area_q;
	status_t             rsp_status_q;

	logic                valid_s1;
	logic                last_s1;
	logic                qv_s1;
	logic [1:0]          qidx_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic [PART_W-1:0]   part_s1;
	logic                in_rect_s1;

	logic [DIM_W-1:0]    gw_eff;
	logic [DIM_W-1:0]    gh_eff;
	logic [DIM_W:0]      x_sum;
	logic [DIM_W:0]      y_sum;
	logic                empty;
	logic                inside_grid;
	logic                accept;
	state_t              acc_next;
	status_t             acc_status;
	logic                go_check;
	logic                fail;

	scan_cfg_t           scan_cfg;
	scan_pt_t            pt;
	logic                scan_start;

	logic [COL_W-1:0]    q_xl;
	logic [COL_W-1:0]    q_xp;
	logic [ROW_W-1:0]    q_yl;
	logic [ROW_W-1:0]    q_yp;
	logic [COL_W-1:0]    qx;
	logic [ROW_W-1:0]    qy;
	logic [ADDR_W-1:0]   rd_addr;

	logic [DIM_W-1:0]    dx;
	logic [DIM_W-1:0]    dy;
	logic [DIM_W-1:0]    mx;
	logic [DIM_W-1:0]    my;

	logic [COUNT_BITS-1:0] cnt_rd;
	logic [SUM_W-1:0]      area_rd;
	logic                  clearing;
	logic                  upd;
	logic                  area_we;
	logic                  cnt_we;
	logic [ADDR_W-1:0]     waddr;
	logic [COUNT_BITS-1:0] cnt_wd;
	logic [SUM_W-1:0]      area_wd;

	alu_op_t               alu_op;
	logic [SUM_W-1:0]      alu_sum;
	logic [AREA_W-1:0]     acc_clamped;
	logic                  rsp_free;

	// request decode
	always_comb begin
		gw_eff      = (width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q;
		gh_eff      = (height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q;
		x_sum       = (DIM_W+1)'(req.rect_x) + (DIM_W+1)'(req.rect_w);
		y_sum       = (DIM_W+1)'(req.rect_y) + (DIM_W+1)'(req.rect_h);
		empty       = (req.rect_w == '0) || (req.rect_h == '0);
		inside_grid = (x_sum <= (DIM_W+1)'(gw_eff)) && (y_sum <= (DIM_W+1)'(gh_eff));
		accept      = req.valid && req.ready;

		acc_next   = S_DONE;
		acc_status = ST_RANGE;
		go_check   = 1'b0;
		unique case (req.func) inside
			FN_QUERY: begin
				if (!empty && inside_grid) begin
					acc_next   = S_QUERY;
					acc_status = ST_OK;
				end
			end
			FN_INSERT, FN_REMOVE: begin
				if (empty) begin
					acc_status = ST_OK;
				end else if (inside_grid) begin
					acc_next   = S_CHECK;
					acc_status = ST_OK;
					go_check   = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign req.ready = (state_q == S_IDLE);

	// count check on the data returned for the previous scan point
	assign fail = (state_q == S_CHECK) && valid_s1 &&
		((func_q == FN_REMOVE) ? (cnt_rd == '0) : (cnt_rd == COUNT_MAX));

	always_comb begin
		if (state_q == S_IDLE) begin
			scan_cfg.x0    = req.rect_x;
			scan_cfg.y0    = req.rect_y;
			scan_cfg.x_end = x_sum[DIM_W-1:0];
			scan_cfg.y_end = y_sum[DIM_W-1:0];
		end else begin
			scan_cfg.x0    = rx_q;
			scan_cfg.y0    = ry_q;
			scan_cfg.x_end = gw_q;
			scan_cfg.y_end = gh_q;
		end
		scan_start = (accept && go_check) ||
			((state_q == S_CHECK) && valid_s1 && last_s1 && !fail);
	end

	sact_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scan_start),
		.abort  (fail),
		.cfg    (scan_cfg),
		.pt     (pt)
	);

	// corners d, b, c, a of the four-corner difference
	always_comb begin
		q_xl = rx_q + COL_W'(rw_q - DIM_W'(1));
		q_yl = ry_q + ROW_W'(rh_q - DIM_W'(1));
		q_xp = rx_q - COL_W'(1);
		q_yp = ry_q - ROW_W'(1);
		qx   = qidx_q[0] ? q_xp : q_xl;
		qy   = qidx_q[1] ? q_yp : q_yl;
		rd_addr = (state_q == S_QUERY) ? {qy, qx} : {pt.y, pt.x};
	end

	// share of the rectangle inside the prefix region of the scan point
	always_comb begin
		dx = DIM_W'(pt.x) - DIM_W'(rx_q) + DIM_W'(1);
		dy = DIM_W'(pt.y) - DIM_W'(ry_q) + DIM_W'(1);
		mx = (dx < rw_q) ? dx : rw_q;
		my = (dy < rh_q) ? dy : rh_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			qv_s1    <= 1'b0;
		end else begin
			valid_s1 <= pt.valid;
			qv_s1    <= (state_q == S_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		last_s1    <= pt.last;
		qidx_s1    <= qidx_q;
		addr_s1    <= {pt.y, pt.x};
		part_s1    <= PART_W'(mx) * PART_W'(my);
		in_rect_s1 <= (dx <= rw_q) && (dy <= rh_q);
	end

	always_comb begin
		alu_op = ALU_HOLD;
		if ((state_q == S_UPDATE) && valid_s1) begin
			alu_op = (func_q == FN_INSERT) ? ALU_CELL_ADD : ALU_CELL_SUB;
		end else if (qv_s1) begin
			unique case (qidx_s1)
				2'd0: alu_op = ALU_LOAD;
				2'd1: alu_op = (rx_q != '0) ? ALU_ACC_SUB : ALU_HOLD;
				2'd2: alu_op = (ry_q != '0) ? ALU_ACC_SUB : ALU_HOLD;
				2'd3: alu_op = ((rx_q != '0) && (ry_q != '0)) ? ALU_ACC_ADD : ALU_HOLD;
				default: alu_op = ALU_HOLD;
			endcase
		end
	end

	sact_alu u_alu (
		.clk         (clk),
		.op          (alu_op),
		.mem         (area_rd),
		.part        (part_s1),
		.sum         (alu_sum),
		.acc_clamped (acc_clamped)
	);

	always_comb begin
		clearing = (state_q == S_CLEAR);
		upd      = (state_q == S_UPDATE) && valid_s1;
		area_we  = clearing || upd;
		cnt_we   = clearing || (upd && in_rect_s1);
		waddr    = clearing ? clr_q : addr_s1;
		area_wd  = clearing ? '0 : alu_sum;
		if (clearing) begin
			cnt_wd = '0;
		end else if (func_q == FN_INSERT) begin
			cnt_wd = cnt_rd + COUNT_BITS'(1);
		end else begin
			cnt_wd = cnt_rd - COUNT_BITS'(1);
		end
	end

	sact_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (CELLS)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (waddr),
		.wdata (cnt_wd),
		.raddr (rd_addr),
		.rdata (cnt_rd)
	);

	sact_ram #(
		.WIDTH (SUM_W),
		.DEPTH (CELLS)
	) u_area_ram (
		.clk   (clk),
		.we    (area_we),
		.waddr (waddr),
		.wdata (area_wd),
		.raddr (rd_addr),
		.rdata (area_rd)
	);

	assign rsp_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			width_q      <= DIM_W'(MAX_WIDTH);
			height_q     <= DIM_W'(MAX_HEIGHT);
			rx_q         <= '0;
			ry_q         <= '0;
			rw_q         <= '0;
			rh_q         <= '0;
			gw_q         <= '0;
			gh_q         <= '0;
			func_q       <= '0;
			qidx_q       <= '0;
			query_q      <= 1'b0;
			res_status_q <= ST_OK;
			rsp_valid_q  <= 1'b0;
			rsp_area_q   <= '0;
			rsp_status_q <= ST_OK;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GRID_WIDTH:  width_q  <= cfg_data;
					REG_GRID_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end

			if ((state_q == S_DONE) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						rx_q         <= req.rect_x;
						ry_q         <= req.rect_y;
						rw_q         <= req.rect_w;
						rh_q         <= req.rect_h;
						gw_q         <= gw_eff;
						gh_q         <= gh_eff;
						func_q       <= req.func;
						qidx_q       <= '0;
						query_q      <= (acc_next == S_QUERY);
						res_status_q <= acc_status;
						state_q      <= acc_next;
					end
				end
				S_CHECK: begin
					if (fail) begin
						res_status_q <= (func_q == FN_REMOVE) ? ST_UNCOVERED : ST_OVERFLOW;
						state_q      <= S_DONE;
					end else if (valid_s1 && last_s1) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					if (valid_s1 && last_s1) begin
						state_q <= S_DONE;
					end
				end
				S_QUERY: begin
					qidx_q <= qidx_q + 2'd1;
					if (qidx_q == 2'd3) begin
						state_q <= S_QWAIT;
					end
				end
				S_QWAIT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_free) begin
						rsp_area_q   <= query_q ? acc_clamped : '0;
						rsp_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.covered_area = rsp_area_q;
	assign rsp.status       = rsp_status_q;

	a_cnt_with_area: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_we |-> area_we)
		else $error("count written without its area cell");

	a_update_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPDATE && valid_s1) |->
			(DIM_W'(addr_s1[COL_W-1:0]) < gw_q) && (DIM_W'(addr_s1[ADDR_W-1:COL_W]) < gh_q))
		else $error("area update outside the grid");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the done step");

	a_reject_zero_area: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_OK) |-> (rsp.covered_area == '0))
		else $error("rejected request carries an area");

endmodule

FILE: hdl/sact_ram.sv
`timescale 1ns / 1ps

module sact_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/sact_scan.sv
`timescale 1ns / 1ps

module sact_scan import sact_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      abort,
	input  scan_cfg_t cfg,
	output scan_pt_t  pt
);

	logic             run_q;
	logic [COL_W-1:0] x_q;
	logic [ROW_W-1:0] y_q;
	logic [COL_W-1:0] x0_q;
	logic [DIM_W-1:0] x_end_q;
	logic [DIM_W-1:0] y_end_q;
	logic             x_wrap;
	logic             y_wrap;

	assign x_wrap = (DIM_W'(x_q) + DIM_W'(1)) == x_end_q;
	assign y_wrap = (DIM_W'(y_q) + DIM_W'(1)) == y_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else if (start) begin
			run_q <= 1'b1;
		end else if (abort) begin
			run_q <= 1'b0;
		end else if (run_q && x_wrap && y_wrap) begin
			run_q <= 1'b0;
		end
	end

	// raster walk, row by row
	always_ff @(posedge clk) begin
		if (start) begin
			x_q     <= cfg.x0;
			y_q     <= cfg.y0;
			x0_q    <= cfg.x0;
			x_end_q <= cfg.x_end;
			y_end_q <= cfg.y_end;
		end else if (run_q) begin
			if (x_wrap) begin
				x_q <= x0_q;
				if (!y_wrap) begin
					y_q <= y_q + ROW_W'(1);
				end
			end else begin
				x_q <= x_q + COL_W'(1);
			end
		end
	end

	assign pt.valid = run_q;
	assign pt.last  = run_q && x_wrap && y_wrap;
	assign pt.x     = x_q;
	assign pt.y     = y_q;

	a_start_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (cfg.x_end > DIM_W'(cfg.x0)) && (cfg.y_end > DIM_W'(cfg.y0)))
		else $error("scan started on an empty region");

	a_x_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> (DIM_W'(x_q) < x_end_q))
		else $error("scan column past its end");

	a_y_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> (DIM_W'(y_q) < y_end_q))
		else $error("scan row past its end");

endmodule

FILE: hdl/sact_alu.sv
`timescale 1ns / 1ps

module sact_alu import sact_pkg::*; (
	input  logic              clk,
	input  alu_op_t           op,
	input  logic [SUM_W-1:0]  mem,
	input  logic [PART_W-1:0] part,
	output logic [SUM_W-1:0]  sum,
	output logic [AREA_W-1:0] acc_clamped
);

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] mem_ext;
	logic signed [ACC_W-1:0] opa;
	logic signed [ACC_W-1:0] opb;
	logic signed [ACC_W-1:0] res;
	logic                    use_acc;
	logic                    sub;

	always_comb begin
		mem_ext = {{(ACC_W-SUM_W){mem[SUM_W-1]}}, mem};
		use_acc = op inside {ALU_ACC_ADD, ALU_ACC_SUB};
		sub     = op inside {ALU_ACC_SUB, ALU_CELL_SUB};
		opa     = use_acc ? acc_q : mem_ext;
		opb     = use_acc ? mem_ext : {{(ACC_W-PART_W){1'b0}}, part};
		res     = sub ? (opa - opb) : (opa + opb);
		sum     = res[SUM_W-1:0];
	end

	always_ff @(posedge clk) begin
		case (op) inside
			ALU_LOAD:                 acc_q <= mem_ext;
			ALU_ACC_ADD, ALU_ACC_SUB: acc_q <= res;
			default:                  ;
		endcase
	end

	// saturate the four-corner sum into the result range
	always_comb begin
		if (acc_q[ACC_W-1]) begin
			acc_clamped = '0;
		end else if (|acc_q[ACC_W-2:AREA_W]) begin
			acc_clamped = AREA_MAX;
		end else begin
			acc_clamped = acc_q[AREA_W-1:0];
		end
	end

endmodule

FILE: sim/summed_area_coverage_table_top_tb.sv
`timescale 1ns / 1ps

module summed_area_coverage_table_top_tb;
	import sact_pkg::*;

	localparam logic [FUNC_W-1:0] FN_RESERVED = 2'd3;
	localparam int STALL_LIMIT = 40000;
	localparam int HOLD_CYCLES = 2000;
	localparam int CORNER = 63;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [POS_W-1:0]  rect_x;
		logic [POS_W-1:0]  rect_y;
		logic [DIM_W-1:0]  rect_w;
		logic [DIM_W-1:0]  rect_h;
	} coverage_req_t;

	typedef struct packed {
		logic [AREA_W-1:0] covered_area;
		status_t           status;
	} coverage_rsp_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sact_req_if req_ch();
	sact_rsp_if rsp_ch();

	summed_area_coverage_table_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// predictor state
	bit [COUNT_BITS-1:0] pixel_count [CELLS];
	longint              area_table [CELLS];
	bit [DIM_W-1:0]      grid_cols_reg = 7'd64;
	bit [DIM_W-1:0]      grid_rows_reg = 7'd64;

	coverage_req_t pending_requests[$];
	coverage_rsp_t expected_results[$];
	coverage_req_t placed_rects[$];

	logic req_fire = 1'b0;
	int   req_gap = 0;
	int   rsp_hold = 0;
	int   req_idle_pct = 0;
	int   rsp_idle_pct = 0;
	bit   pressure_armed = 1'b0;
	bit   pressure_done = 1'b0;
	int   stall_cycles = 0;
	int   mismatch_count = 0;
	int   n_insert = 0, n_remove = 0, n_query = 0, n_unused = 0, n_turned_away = 0;

	function automatic int cell_at(input int x, input int y);
		return y * MAX_WIDTH + x;
	endfunction

	function automatic int clip_dim(input int v, input int lim);
		return (v > lim) ? lim : v;
	endfunction

	function automatic coverage_rsp_t apply_request(input coverage_req_t r);
		coverage_rsp_t res;
		int gw, gh, rx, ry, rw, rh, x, y, i;
		bit empty, fits;
		longint a, b, c, d, s, part;
		gw = clip_dim(int'(grid_cols_reg), MAX_WIDTH);
		gh = clip_dim(int'(grid_rows_reg), MAX_HEIGHT);
		rx = int'(r.rect_x);
		ry = int'(r.rect_y);
		rw = int'(r.rect_w);
		rh = int'(r.rect_h);
		empty = (rw == 0) || (rh == 0);
		fits = (rx + rw <= gw) && (ry + rh <= gh);
		res.covered_area = '0;
		res.status = ST_OK;
		if (r.func == FN_QUERY) begin
			if (empty || !fits) begin
				res.status = ST_RANGE;
			end else begin
				d = area_table[cell_at(rx + rw - 1, ry + rh - 1)];
				b = (rx > 0) ? area_table[cell_at(rx - 1, ry + rh - 1)] : 64'sd0;
				c = (ry > 0) ? area_table[cell_at(rx + rw - 1, ry - 1)] : 64'sd0;
				a = (rx > 0 && ry > 0) ? area_table[cell_at(rx - 1, ry - 1)] : 64'sd0;
				s = d - b - c + a;
				// a stale table after a resize can push the sum out of range
				if (s < 0)
					s = 0;
				if (s > longint'(AREA_MAX))
					s = longint'(AREA_MAX);
				res.covered_area = s[AREA_W-1:0];
			end
		end else if (r.func != FN_INSERT && r.func != FN_REMOVE) begin
			res.status = ST_RANGE;
		end else if (!empty) begin
			if (!fits) begin
				res.status = ST_RANGE;
			end else begin
				for (y = ry; y < ry + rh; y++)
					for (x = rx; x < rx + rw; x++) begin
						i = cell_at(x, y);
						if (r.func == FN_REMOVE && pixel_count[i] == 0)
							res.status = ST_UNCOVERED;
						else if (r.func == FN_INSERT && pixel_count[i] == COUNT_MAX)
							res.status = ST_OVERFLOW;
					end
				if (res.status == ST_OK) begin
					for (y = ry; y < ry + rh; y++)
						for (x = rx; x < rx + rw; x++) begin
							i = cell_at(x, y);
							if (r.func == FN_INSERT)
								pixel_count[i] = pixel_count[i] + COUNT_BITS'(1);
							else
								pixel_count[i] = pixel_count[i] - COUNT_BITS'(1);
						end
					// every area cell right of and below the corner within the grid
					for (y = ry; y < gh; y++)
						for (x = rx; x < gw; x++) begin
							part = longint'((x - rx + 1 < rw) ? x - rx + 1 : rw) *
								longint'((y - ry + 1 < rh) ? y - ry + 1 : rh);
							i = cell_at(x, y);
							if (r.func == FN_INSERT)
								area_table[i] = area_table[i] + part;
							else
								area_table[i] = area_table[i] - part;
						end
				end
			end
		end
		return res;
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!(req_ch.valid && !req_fire)) begin
			if (req_gap == 0 && req_idle_pct != 0 && $urandom_range(99) < req_idle_pct)
				req_gap = $urandom_range(1, 19);
			if (req_gap != 0) begin
				req_gap--;
				req_ch.valid <= 1'b0;
			end else if (pending_requests.size() != 0) begin
				req_ch.valid <= 1'b1;
				{req_ch.func, req_ch.rect_x, req_ch.rect_y, req_ch.rect_w, req_ch.rect_h}
					<= pending_requests[0];
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver readiness
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			// long hold-off so the block fills up and stops taking requests
			if (pressure_armed && !pressure_done && pending_requests.size() >= 20) begin
				rsp_hold = HOLD_CYCLES;
				pressure_done = 1'b1;
			end
			if (rsp_hold == 0 && rsp_idle_pct != 0 && $urandom_range(99) < rsp_idle_pct)
				rsp_hold = $urandom_range(1, 19);
			if (rsp_hold != 0) begin
				rsp_hold--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// monitor: checks results, predicts accepted requests, watches for a hang
	always @(posedge clk) begin
		coverage_rsp_t want;
		coverage_req_t got;
		req_fire <= arst_n && req_ch.valid && req_ch.ready;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no request waiting: covered_area %0d status %0d",
						rsp_ch.covered_area, rsp_ch.status);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (rsp_ch.covered_area !== want.covered_area) begin
						$error("covered_area mismatch: expected %0d, actual %0d",
							want.covered_area, rsp_ch.covered_area);
						mismatch_count++;
					end
					if (rsp_ch.status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							want.status, rsp_ch.status);
						mismatch_count++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				got = {req_ch.func, req_ch.rect_x, req_ch.rect_y, req_ch.rect_w, req_ch.rect_h};
				want = apply_request(got);
				expected_results.push_back(want);
				void'(pending_requests.pop_front());
				if (got.func == FN_INSERT)
					n_insert++;
				else if (got.func == FN_REMOVE)
					n_remove++;
				else if (got.func == FN_QUERY)
					n_query++;
				else
					n_unused++;
				if (want.status != ST_OK)
					n_turned_away++;
			end
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("no handshake for %0d cycles", STALL_LIMIT);
				$display("summed_area_coverage_table_top_tb failed");
				$finish;
			end
		end
	end

	task automatic push_request(input logic [FUNC_W-1:0] func, input int x, input int y,
			input int w, input int h);
		coverage_req_t item;
		item.func = func;
		item.rect_x = POS_W'(x);
		item.rect_y = POS_W'(y);
		item.rect_w = DIM_W'(w);
		item.rect_h = DIM_W'(h);
		pending_requests.push_back(item);
	endtask

	task automatic wait_for_drain();
		while (pending_requests.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_grid_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		if (idx == REG_GRID_WIDTH)
			grid_cols_reg = value;
		else
			grid_rows_reg = value;
		@(negedge clk);
		cfg_we = 1'b0;
		@(posedge clk);
	endtask

	// mostly well-formed rectangles; min_pos pulls inserts toward the far corner
	task automatic queue_random_items(input int count, input int min_pos);
		coverage_req_t item;
		int gw, gh, lo_x, lo_y, pick, k, j;
		gw = clip_dim(int'(grid_cols_reg), MAX_WIDTH);
		gh = clip_dim(int'(grid_rows_reg), MAX_HEIGHT);
		lo_x = (min_pos < gw) ? min_pos : 0;
		lo_y = (min_pos < gh) ? min_pos : 0;
		for (k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			if (pick < 15) begin
				item.func = FUNC_W'($urandom_range(3));
				item.rect_x = POS_W'($urandom_range(63));
				item.rect_y = POS_W'($urandom_range(63));
				item.rect_w = DIM_W'($urandom_range(64));
				item.rect_h = DIM_W'($urandom_range(64));
			end else if (pick < 32 && placed_rects.size() != 0) begin
				j = $urandom_range(placed_rects.size() - 1);
				item = placed_rects[j];
				item.func = FN_REMOVE;
				placed_rects.delete(j);
			end else if (pick < 62) begin
				item.func = FN_INSERT;
				item.rect_x = POS_W'($urandom_range(lo_x, gw - 1));
				item.rect_y = POS_W'($urandom_range(lo_y, gh - 1));
				item.rect_w = DIM_W'($urandom_range(1, (gw - int'(item.rect_x) < 8) ?
					gw - int'(item.rect_x) : 8));
				item.rect_h = DIM_W'($urandom_range(1, (gh - int'(item.rect_y) < 8) ?
					gh - int'(item.rect_y) : 8));
				placed_rects.push_back(item);
			end else begin
				item.func = (pick < 94) ? FN_QUERY : FN_REMOVE;
				item.rect_x = POS_W'($urandom_range(gw - 1));
				item.rect_y = POS_W'($urandom_range(gh - 1));
				item.rect_w = DIM_W'($urandom_range(1, gw - int'(item.rect_x)));
				item.rect_h = DIM_W'($urandom_range(1, gh - int'(item.rect_y)));
				if (item.func == FN_REMOVE) begin
					item.rect_w = (item.rect_w > DIM_W'(4)) ? DIM_W'(4) : item.rect_w;
					item.rect_h = (item.rect_h > DIM_W'(4)) ? DIM_W'(4) : item.rect_h;
				end
			end
			pending_requests.push_back(item);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed: full grid, edges, empty and rejected requests, reserved op
		req_idle_pct = 10;
		rsp_idle_pct = 10;
		push_request(FN_QUERY, 0, 0, 64, 64);
		push_request(FN_INSERT, 0, 0, 64, 64);
		push_request(FN_QUERY, 0, 0, 64, 64);
		push_request(FN_QUERY, 63, 63, 1, 1);
		push_request(FN_INSERT, 60, 62, 4, 2);
		push_request(FN_QUERY, 59, 61, 5, 3);
		push_request(FN_INSERT, 63, 63, 0, 5);
		push_request(FN_REMOVE, 10, 10, 3, 0);
		push_request(FN_REMOVE, 63, 40, 0, 64);
		push_request(FN_QUERY, 5, 5, 0, 4);
		push_request(FN_INSERT, 63, 0, 2, 1);
		push_request(FN_REMOVE, 0, 63, 1, 2);
		push_request(FN_QUERY, 1, 0, 64, 1);
		push_request(FN_RESERVED, 21, 42, 17, 33);
		push_request(FN_REMOVE, 0, 0, 64, 64);
		push_request(FN_REMOVE, 58, 62, 4, 2);
		push_request(FN_REMOVE, 60, 62, 4, 2);
		push_request(FN_QUERY, 0, 0, 64, 64);
		push_request(FN_INSERT, 32, 32, 32, 32);
		push_request(FN_INSERT, 40, 36, 8, 20);
		push_request(FN_QUERY, 33, 40, 10, 5);
		push_request(FN_QUERY, 0, 0, 64, 64);
		wait_for_drain();

		// zero-sized grid
		write_grid_reg(REG_GRID_WIDTH, 7'd0);
		write_grid_reg(REG_GRID_HEIGHT, 7'd0);
		push_request(FN_INSERT, 0, 0, 1, 1);
		push_request(FN_QUERY, 0, 0, 1, 1);
		push_request(FN_REMOVE, 7, 3, 0, 2);
		wait_for_drain();

		// width saturates to the maximum, one row
		write_grid_reg(REG_GRID_WIDTH, 7'd127);
		write_grid_reg(REG_GRID_HEIGHT, 7'd1);
		queue_random_items(15, 0);
		wait_for_drain();

		// one column, no idling
		req_idle_pct = 0;
		rsp_idle_pct = 0;
		write_grid_reg(REG_GRID_WIDTH, 7'd1);
		write_grid_reg(REG_GRID_HEIGHT, 7'd64);
		queue_random_items(15, 0);
		wait_for_drain();

		// small grid with the receiver held off for a while
		req_idle_pct = 15;
		rsp_idle_pct = 15;
		write_grid_reg(REG_GRID_WIDTH, 7'd12);
		write_grid_reg(REG_GRID_HEIGHT, 7'd9);
		pressure_armed = 1'b1;
		queue_random_items(40, 0);
		wait_for_drain();

		// full grid again; the table is now stale outside the small grids
		req_idle_pct = 10;
		rsp_idle_pct = 10;
		write_grid_reg(REG_GRID_WIDTH, 7'd64);
		write_grid_reg(REG_GRID_HEIGHT, 7'd64);
		queue_random_items(25, 44);
		wait_for_drain();

		req_idle_pct = 0;
		rsp_idle_pct = 0;
		write_grid_reg(REG_GRID_WIDTH, 7'd20);
		write_grid_reg(REG_GRID_HEIGHT, 7'd16);
		queue_random_items(20, 0);
		wait_for_drain();

		// repeated hits on the far corner pixel
		write_grid_reg(REG_GRID_WIDTH, 7'd64);
		write_grid_reg(REG_GRID_HEIGHT, 7'd64);
		push_request(FN_INSERT, CORNER, CORNER, 1, 1);
		push_request(FN_QUERY, CORNER, CORNER, 1, 1);
		push_request(FN_INSERT, CORNER - 1, CORNER, 2, 1);
		push_request(FN_REMOVE, CORNER, CORNER, 1, 1);
		push_request(FN_INSERT, CORNER, CORNER, 1, 1);
		push_request(FN_INSERT, CORNER, CORNER, 1, 1);
		push_request(FN_QUERY, 0, 0, 64, 64);
		wait_for_drain();
		repeat (40) @(posedge clk);

		$display("requests: %0d insert, %0d remove, %0d query, %0d unused op; %0d refused",
			n_insert, n_remove, n_query, n_unused, n_turned_away);
		$display("grids from 0x0 to saturated 64 wide, stale tables after resizes, long rsp hold");
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("summed_area_coverage_table_top_tb passed");
		end else begin
			$display("summed_area_coverage_table_top_tb failed");
		end
		$finish;
	end

endmodule

FILE: summed_area_coverage_table_top.f
hdl/sact_pkg.sv
hdl/sact_req_if.sv
hdl/sact_rsp_if.sv
hdl/sact_ram.sv
hdl/sact_scan.sv
hdl/sact_alu.sv
hdl/summed_area_coverage_table_top.sv
sim/summed_area_coverage_table_top_tb.sv
